[rtl/uhif_pkg.sv]
// ----------------------------------------------------------------------------
// uhif_pkg: shared types and constants
// Field widths, command and register codes, and the pipeline tag that
// travels with each index through the modulo pipeline.
// ----------------------------------------------------------------------------
package uhif_pkg;

    localparam int KEY_W      = 32;
    localparam int COEF_W     = 31;
    localparam int INDEX_W    = 31;
    localparam int SLOT_W     = 4;
    localparam int FNUM_W     = 4;
    localparam int FCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 1;

    // Stream widths: input tdata is slot, coef_mult, coef_add, key_hash.
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 4;

    // Bit offsets inside s_tdata.
    localparam int SLOT_LSB   = 0;
    localparam int MULT_LSB   = SLOT_LSB + SLOT_W;
    localparam int ADD_LSB    = MULT_LSB + COEF_W;
    localparam int KEY_LSB    = ADD_LSB + COEF_W;

    // Most results that one key may produce.
    localparam int RESULT_LIMIT = 16;

    // Remainder pipeline: dividend bits retired per stage and stage count.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = KEY_W / DIV_BITS;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_HASH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_COUNT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [FNUM_W-1:0] fnum;
        logic              last;
    } uhif_tag_t;

endpackage

[rtl/universal_hash_index_family.sv]
// ----------------------------------------------------------------------------
// universal_hash_index_family: Bloom filter index generator
// Produces ((a_i*h + b_i) mod 2^32) mod modulus for each active function i.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries commands. s_tuser[0] selects a load (write one
//   coefficient pair into a table slot) or a hash (key hash in s_tdata).
//   A load produces nothing. A hash with k active functions occupies the
//   sequencer, issuing one function per cycle while the output is not
//   stalled, and produces k results on the output stream, function number in
//   m_tuser and m_tlast on the final one; with k equal to zero it produces
//   nothing. Sustained rate is one index per cycle while the output is not
//   stalled, set by the single read port of the coefficient table.
//   The first index of a key passes through the key register, table read,
//   multiply, add, and 16 remainder stages.
//   Write registers through cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce this.
//   Reset sets modulus to 2 and function_count to 0 and empties the
//   pipeline; the coefficient table keeps its contents and must be loaded.
//   When the receiver holds m_tready low against a valid output, the whole pipeline holds in place
//   and s_tready falls once the sequencer has work pending.
// ----------------------------------------------------------------------------
module universal_hash_index_family #(
    parameter int MAX_FUNCTIONS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [uhif_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [uhif_pkg::INDEX_W-1:0]        cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, lowest bit up: slot[3:0], coef_mult[34:4], coef_add[65:35],
    // key_hash[97:66], zero fill[103:98].
    input  logic [uhif_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: command[0].
    input  logic [0:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, lowest bit up: bucket_index[30:0], zero fill[31].
    output logic [uhif_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: function_number[3:0].
    output logic [uhif_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    localparam int AW  = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
    localparam int LIM = (MAX_FUNCTIONS < uhif_pkg::RESULT_LIMIT) ?
                         MAX_FUNCTIONS : uhif_pkg::RESULT_LIMIT;
    localparam int SW  = 7;

    // Configuration registers.
    logic [uhif_pkg::INDEX_W-1:0]  modulus_reg;
    logic [uhif_pkg::FCOUNT_W-1:0] fcount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= uhif_pkg::INDEX_W'(2);
            fcount_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                uhif_pkg::REG_MODULUS:        modulus_reg <= cfg_wdata;
                uhif_pkg::REG_FUNCTION_COUNT: fcount_reg  <= cfg_wdata[uhif_pkg::FCOUNT_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Input fields.
    logic                         in_cmd;
    logic [uhif_pkg::SLOT_W-1:0]  in_slot;
    logic [uhif_pkg::COEF_W-1:0]  in_mult;
    logic [uhif_pkg::COEF_W-1:0]  in_add;
    logic [uhif_pkg::KEY_W-1:0]   in_key;

    assign in_cmd  = s_tuser[0];
    assign in_slot = s_tdata[uhif_pkg::SLOT_LSB +: uhif_pkg::SLOT_W];
    assign in_mult = s_tdata[uhif_pkg::MULT_LSB +: uhif_pkg::COEF_W];
    assign in_add  = s_tdata[uhif_pkg::ADD_LSB  +: uhif_pkg::COEF_W];
    assign in_key  = s_tdata[uhif_pkg::KEY_LSB  +: uhif_pkg::KEY_W];

    // Active function count, saturated to the table depth and result limit.
    logic [uhif_pkg::FCOUNT_W-1:0] active_k;
    logic [uhif_pkg::FNUM_W-1:0]   klast;

    assign active_k = (fcount_reg > uhif_pkg::FCOUNT_W'(LIM)) ?
                      uhif_pkg::FCOUNT_W'(LIM) : fcount_reg;
    assign klast    = uhif_pkg::FNUM_W'(active_k - uhif_pkg::FCOUNT_W'(1));

    // Pipeline advance: every stage moves unless the output is stalled.
    uhif_pkg::uhif_tag_t out_tag;
    logic                adv;
    assign adv = !out_tag.valid || m_tready;

    // Sequencer.
    logic                         busy_reg, busy_next;
    logic [uhif_pkg::FNUM_W-1:0]  cnt_reg, cnt_next;
    logic [uhif_pkg::KEY_W-1:0]   key_reg;
    logic                         issue;
    logic                         issue_last;
    logic                         s_xfer;

    assign issue      = busy_reg && adv;
    assign issue_last = issue && (cnt_reg == klast);
    assign s_tready   = !busy_reg || issue_last;
    assign s_xfer     = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        priority if (s_xfer && in_cmd == uhif_pkg::CMD_HASH && active_k != '0) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (issue_last) begin
            busy_next = 1'b0;
        end else if (issue) begin
            cnt_next  = cnt_reg + uhif_pkg::FNUM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && in_cmd == uhif_pkg::CMD_HASH) begin
            key_reg <= in_key;
        end
    end

    // Coefficient tables. A load in the same cycle as the last read of the
    // previous key does not disturb that read.
    logic [uhif_pkg::COEF_W-1:0] mult_table [MAX_FUNCTIONS];
    logic [uhif_pkg::COEF_W-1:0] add_table  [MAX_FUNCTIONS];
    logic                        slot_ok;

    assign slot_ok = {3'b000, in_slot} < SW'(MAX_FUNCTIONS);

    always_ff @(posedge aclk) begin
        if (s_xfer && in_cmd == uhif_pkg::CMD_LOAD && slot_ok) begin
            mult_table[AW'(in_slot)] <= in_mult;
            add_table[AW'(in_slot)]  <= in_add;
        end
    end

    // Stage R: table read.
    logic [uhif_pkg::COEF_W-1:0] mult_rd_reg;
    logic [uhif_pkg::COEF_W-1:0] add_rd_reg;
    logic [uhif_pkg::KEY_W-1:0]  key_r_reg;
    uhif_pkg::uhif_tag_t         tag_r_reg, tag_r_next;

    always_comb begin
        tag_r_next.valid = issue;
        tag_r_next.fnum  = cnt_reg;
        tag_r_next.last  = (cnt_reg == klast);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mult_rd_reg <= mult_table[AW'(cnt_reg)];
            add_rd_reg  <= add_table[AW'(cnt_reg)];
            key_r_reg   <= key_reg;
        end
    end

    // Stage M: low 32 bits of a*h.
    logic [uhif_pkg::KEY_W-1:0]  prod_reg, prod_next;
    logic [uhif_pkg::COEF_W-1:0] add_m_reg;
    uhif_pkg::uhif_tag_t         tag_m_reg;

    assign prod_next = {1'b0, mult_rd_reg} * key_r_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= prod_next;
            add_m_reg <= add_rd_reg;
        end
    end

    // Stage A: add offset, wrapping at 2^32.
    logic [uhif_pkg::KEY_W-1:0] sum_reg, sum_next;
    uhif_pkg::uhif_tag_t        tag_a_reg;

    assign sum_next = prod_reg + {1'b0, add_m_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_r_reg <= '0;
            tag_m_reg <= '0;
            tag_a_reg <= '0;
        end else if (adv) begin
            tag_r_reg <= tag_r_next;
            tag_m_reg <= tag_r_reg;
            tag_a_reg <= tag_m_reg;
        end
    end

    // Remainder stages; the last stage doubles as the output register.
    logic [uhif_pkg::INDEX_W-1:0] rem;

    uhif_mod_pipe u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .modulus  (modulus_reg),
        .in_tag   (tag_a_reg),
        .in_value (sum_reg),
        .out_tag  (out_tag),
        .out_rem  (rem)
    );

    // A zero modulus yields index zero.
    assign m_tvalid = out_tag.valid;
    assign m_tdata  = {1'b0, (modulus_reg == '0) ? uhif_pkg::INDEX_W'(0) : rem};
    assign m_tuser  = out_tag.fnum;
    assign m_tlast  = out_tag.last;

endmodule

[rtl/uhif_mod_pipe.sv]
// ----------------------------------------------------------------------------
// uhif_mod_pipe: pipelined 32-bit remainder unit
// Restoring remainder of a 32-bit value by the 31-bit modulus, two
// dividend bits per stage, with the item tag carried alongside.
// ----------------------------------------------------------------------------
module uhif_mod_pipe (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic [uhif_pkg::INDEX_W-1:0]      modulus,
    input  uhif_pkg::uhif_tag_t               in_tag,
    input  logic [uhif_pkg::KEY_W-1:0]        in_value,
    output uhif_pkg::uhif_tag_t               out_tag,
    output logic [uhif_pkg::INDEX_W-1:0]      out_rem
);

    localparam int NS = uhif_pkg::DIV_STAGES;
    localparam int W  = uhif_pkg::KEY_W;

    uhif_pkg::uhif_tag_t tag_reg  [NS];
    logic [W-1:0]        rem_reg  [NS];
    logic [W-1:0]        dvd_reg  [NS];

    uhif_pkg::uhif_tag_t tag_in   [NS];
    logic [W-1:0]        rem_in   [NS];
    logic [W-1:0]        dvd_in   [NS];
    logic [W-1:0]        rem_next [NS];
    logic [W-1:0]        dvd_next [NS];

    logic [W-1:0] mod_ext;
    assign mod_ext = {1'b0, modulus};

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign tag_in[s] = in_tag;
            assign rem_in[s] = '0;
            assign dvd_in[s] = in_value;
        end else begin : g_rest
            assign tag_in[s] = tag_reg[s-1];
            assign rem_in[s] = rem_reg[s-1];
            assign dvd_in[s] = dvd_reg[s-1];
        end

        // For a nonzero modulus the partial remainder stays below it, so its top bit is
        // always clear and the shift never overflows 32 bits.
        always_comb begin : p_step
            logic [W-1:0] r;
            logic [W-1:0] d;
            r = rem_in[s];
            d = dvd_in[s];
            for (int j = 0; j < uhif_pkg::DIV_BITS; j++) begin
                r = {r[W-2:0], d[W-1]};
                d = {d[W-2:0], 1'b0};
                if (r >= mod_ext) begin
                    r = r - mod_ext;
                end
            end
            rem_next[s] = r;
            dvd_next[s] = d;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[s] <= '0;
            end else if (adv) begin
                tag_reg[s] <= tag_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s] <= rem_next[s];
                dvd_reg[s] <= dvd_next[s];
            end
        end
    end

    assign out_tag = tag_reg[NS-1];
    assign out_rem = rem_reg[NS-1][uhif_pkg::INDEX_W-1:0];

endmodule

[rtl/uhif_checker.sv]
// ----------------------------------------------------------------------------
// uhif_checker: port-level checks for the index generator
// Watches the output stream for function order, tlast on 15, stalls, reset.
// ----------------------------------------------------------------------------
module uhif_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [uhif_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [uhif_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);

    logic                          out_xfer;
    logic [uhif_pkg::FNUM_W-1:0]   exp_fn_reg;

    assign out_xfer = m_tvalid && m_tready;

    // Function numbers of a key run from zero upward until the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_fn_reg <= '0;
        end else if (out_xfer) begin
            exp_fn_reg <= m_tlast ? '0 : m_tuser + uhif_pkg::FNUM_W'(1);
        end
    end

    a_fn_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> m_tuser == exp_fn_reg)
        else $error("function number out of sequence");

    a_fn_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == 4'hF) |-> m_tlast)
        else $error("sixteenth function not marked last");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled transfer changed");

endmodule

bind universal_hash_index_family uhif_checker u_uhif_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
